>>> src/bmph_pkg.sv
// ----------------------------------------------------------------------------
// bmph_pkg
// shared types, constants and the bar color table of the bar meter
// ----------------------------------------------------------------------------
package bmph_pkg;

   localparam int CH_BITS    = 4;
   localparam int LVL_BITS   = 6;
   localparam int ROW_BITS   = 5;
   localparam int X_BITS     = 6;
   localparam int COLOR_BITS = 24;
   localparam int DCNT_BITS  = 16;
   localparam int MASK_BITS  = 8;
   localparam int CSR_ABITS  = 3;
   localparam int CSR_DBITS  = 32;

   localparam logic [COLOR_BITS-1:0] PEAK_COLOR = 24'hff0000;

   localparam logic CSR_DECAY_MASK = 1'b0;
   localparam logic CSR_MAX_DECAY  = 1'b1;

   localparam logic [MASK_BITS-1:0] DECAY_MASK_RST = 8'd7;
   localparam logic [DCNT_BITS-1:0] MAX_DECAY_RST  = 16'd224;

   typedef struct packed {
      logic load;
      logic emit_bar;
      logic emit_peak;
   } cmd_type;

   typedef struct packed {
      logic chan_ok;
      logic bars_zero;
      logic bar_final;
      logic out_free;
   } status_type;

   function automatic logic [COLOR_BITS-1:0] bar_color(input logic [ROW_BITS-1:0] idx);
      logic [COLOR_BITS-1:0] c;
      case (idx)
         5'd0:    c = 24'h004e04;
         5'd1:    c = 24'h005203;
         5'd2:    c = 24'h005301;
         5'd3:    c = 24'h005600;
         5'd4:    c = 24'h015b00;
         5'd5:    c = 24'h035c00;
         5'd6:    c = 24'h056000;
         5'd7:    c = 24'h086500;
         5'd8:    c = 24'h0b6900;
         5'd9:    c = 24'h0f6b00;
         5'd10:   c = 24'h147100;
         5'd11:   c = 24'h1b7500;
         5'd12:   c = 24'h237a00;
         5'd13:   c = 24'h2d7e00;
         5'd14:   c = 24'h398300;
         5'd15:   c = 24'h488700;
         5'd16:   c = 24'h5e8c00;
         5'd17:   c = 24'h809100;
         5'd18:   c = 24'h968300;
         5'd19:   c = 24'h9b6700;
         5'd20:   c = 24'ha05200;
         5'd21:   c = 24'ha54200;
         5'd22:   c = 24'hab3600;
         5'd23:   c = 24'hb02b00;
         5'd24:   c = 24'hb82200;
         5'd25:   c = 24'hbb1a00;
         5'd26:   c = 24'hc31400;
         5'd27:   c = 24'hc90e00;
         5'd28:   c = 24'hcf0a00;
         5'd29:   c = 24'hd50700;
         5'd30:   c = 24'hda0400;
         default: c = 24'he00200;
      endcase
      return c;
   endfunction

endpackage

>>> src/bmph_if.sv
// ----------------------------------------------------------------------------
// bmph_if
// valid/ready channels for level requests and segment responses
// ----------------------------------------------------------------------------
interface bmph_req_if import bmph_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_BITS-1:0]  channel;
   logic [LVL_BITS-1:0] level;

   modport source (output valid, channel, level, input ready);
   modport sink (input valid, channel, level, output ready);
endinterface

interface bmph_rsp_if import bmph_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [X_BITS-1:0]     x_start;
   logic [ROW_BITS-1:0]   row;
   logic [COLOR_BITS-1:0] color;
   logic                  is_peak;
   logic                  last;

   modport source (output valid, x_start, row, color, is_peak, last, input ready);
   modport sink (input valid, x_start, row, color, is_peak, last, output ready);
endinterface

>>> src/bmph_csr.sv
// ----------------------------------------------------------------------------
// bmph_csr
// apb register file holding the decay mask and the decay ceiling
// ----------------------------------------------------------------------------
module bmph_csr import bmph_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_ABITS-1:0] paddr,
   input  logic [CSR_DBITS-1:0] pwdata,
   output logic [CSR_DBITS-1:0] prdata,
   output logic [MASK_BITS-1:0] decay_mask,
   output logic [DCNT_BITS-1:0] max_decay
);

   logic [MASK_BITS-1:0] decay_mask_ff;
   logic [DCNT_BITS-1:0] max_decay_ff;
   logic                 wr_en;
   logic                 reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_mask_ff <= DECAY_MASK_RST;
         max_decay_ff  <= MAX_DECAY_RST;
      end else if (wr_en) begin
         case (reg_idx)
            CSR_DECAY_MASK: decay_mask_ff <= pwdata[MASK_BITS-1:0];
            CSR_MAX_DECAY:  max_decay_ff  <= pwdata[DCNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_DECAY_MASK: prdata = {{(CSR_DBITS-MASK_BITS){1'b0}}, decay_mask_ff};
         CSR_MAX_DECAY:  prdata = {{(CSR_DBITS-DCNT_BITS){1'b0}}, max_decay_ff};
         default:        prdata = '0;
      endcase
   end

   assign decay_mask = decay_mask_ff;
   assign max_decay  = max_decay_ff;

endmodule

>>> src/bmph_ctrl.sv
// ----------------------------------------------------------------------------
// bmph_ctrl
// sequencer: accept a level, walk the bar rows (if any), then update and send the peak
// ----------------------------------------------------------------------------
module bmph_ctrl import bmph_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BAR  = 3'b010,
      ST_PEAK = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && stat.chan_ok) begin
               state_in = stat.bars_zero ? ST_PEAK : ST_BAR;
            end
         end
         ST_BAR: begin
            if (stat.out_free) begin
               cmd.emit_bar = 1'b1;
               if (stat.bar_final) begin
                  state_in = ST_PEAK;
               end
            end
         end
         ST_PEAK: begin
            if (stat.out_free) begin
               cmd.emit_peak = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/bmph_dp.sv
// ----------------------------------------------------------------------------
// bmph_dp
// datapath: item registers, row counter, per-channel peak state, output stage
// ----------------------------------------------------------------------------
module bmph_dp import bmph_pkg::*; #(
   parameter int ROWS     = 32,
   parameter int CHANNELS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            stat,
   input  logic [CH_BITS-1:0]    req_channel,
   input  logic [LVL_BITS-1:0]   req_level,
   input  logic [MASK_BITS-1:0]  decay_mask,
   input  logic [DCNT_BITS-1:0]  max_decay,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [X_BITS-1:0]     rsp_x_start,
   output logic [ROW_BITS-1:0]   rsp_row,
   output logic [COLOR_BITS-1:0] rsp_color,
   output logic                  rsp_is_peak,
   output logic                  rsp_last
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [LVL_BITS-1:0] ROWS_LVL = LVL_BITS'(ROWS);
   localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(ROWS - 1);
   localparam logic [CH_BITS:0]    CH_LIM   = (CH_BITS + 1)'(CHANNELS);

   logic [CH_BITS-1:0]    ch_ff;
   logic [ROW_BITS-1:0]   hgt_ff;
   logic                  nz_ff;
   logic [ROW_BITS-1:0]   bars_ff;
   logic [ROW_BITS-1:0]   cnt_ff;
   logic [ROW_BITS-1:0]   peak_ff [CHANNELS];
   logic [DCNT_BITS-1:0]  dcnt_ff [CHANNELS];
   logic                  rsp_valid_ff;
   logic [X_BITS-1:0]     x_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  is_peak_ff;
   logic                  last_ff;

   logic [LVL_BITS-1:0]   lvl_sat;
   logic [ROW_BITS-1:0]   hgt_in;
   logic [ROW_BITS-1:0]   bars_in;
   logic [IDX_W-1:0]      idx;
   logic [ROW_BITS-1:0]   pk_cur;
   logic [DCNT_BITS-1:0]  dc_cur;
   logic                  new_peak;
   logic                  mask_hit;
   logic [ROW_BITS-1:0]   pk_in;
   logic [DCNT_BITS-1:0]  dc_in;
   logic [X_BITS-1:0]     x_cur;

   assign lvl_sat = (req_level > ROWS_LVL) ? ROWS_LVL : req_level;
   assign hgt_in  = ROW_BITS'(lvl_sat - 1'b1);
   assign bars_in = (lvl_sat != '0) ? hgt_in : '0;

   assign stat.chan_ok   = {1'b0, req_channel} < CH_LIM;
   assign stat.bars_zero = (bars_in == '0);
   assign stat.bar_final = (ROW_BITS'(cnt_ff + 1'b1) == bars_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= req_channel;
         hgt_ff  <= hgt_in;
         nz_ff   <= (lvl_sat != '0);
         bars_ff <= bars_in;
         cnt_ff  <= '0;
      end else if (cmd.emit_bar) begin
         cnt_ff <= ROW_BITS'(cnt_ff + 1'b1);
      end
   end

   assign idx    = ch_ff[IDX_W-1:0];
   assign pk_cur = peak_ff[idx];
   assign dc_cur = dcnt_ff[idx];

   assign new_peak = nz_ff && (hgt_ff >= pk_cur);
   assign mask_hit = ((dc_cur[MASK_BITS-1:0] & decay_mask) == decay_mask);

   always_comb begin
      if (new_peak) begin
         pk_in = hgt_ff;
         dc_in = '0;
      end else begin
         pk_in = (mask_hit && pk_cur != '0) ? ROW_BITS'(pk_cur - 1'b1) : pk_cur;
         dc_in = (dc_cur < max_decay) ? DCNT_BITS'(dc_cur + 1'b1) : dc_cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            peak_ff[i] <= '0;
            dcnt_ff[i] <= '0;
         end else if (cmd.emit_peak && idx == IDX_W'(i)) begin
            peak_ff[i] <= pk_in;
            dcnt_ff[i] <= dc_in;
         end
      end
   end

   assign x_cur = {ch_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_bar || cmd.emit_peak) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_bar) begin
         x_ff       <= x_cur;
         row_ff     <= ROW_BITS'(ROW_LAST - cnt_ff);
         color_ff   <= bar_color(cnt_ff);
         is_peak_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else if (cmd.emit_peak) begin
         x_ff       <= x_cur;
         row_ff     <= ROW_BITS'(ROW_LAST - pk_in);
         color_ff   <= PEAK_COLOR;
         is_peak_ff <= 1'b1;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_start = x_ff;
   assign rsp_row     = row_ff;
   assign rsp_color   = color_ff;
   assign rsp_is_peak = is_peak_ff;
   assign rsp_last    = last_ff;

endmodule

>>> src/bar_meter_peak_hold_unit.sv
// ----------------------------------------------------------------------------
// bar_meter_peak_hold_unit
// first segment: emitted from the bar or peak state after the level is accepted, then registered
// throughput: one segment a cycle while the output is free, bar segments first and the peak last
// a new level is accepted only in idle, once the peak segment of the last one has been emitted
// reset: synchronous, clears peaks, decay counters and registers to defaults
// ----------------------------------------------------------------------------
module bar_meter_peak_hold_unit import bmph_pkg::*; #(
   parameter int ROWS     = 32,
   parameter int CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   bmph_req_if.sink             req_bus,
   bmph_rsp_if.source           rsp_bus,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_ABITS-1:0] csr_paddr,
   input  logic [CSR_DBITS-1:0] csr_pwdata,
   output logic [CSR_DBITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cmd_type              cmd;
   status_type           stat;
   logic [MASK_BITS-1:0] decay_mask;
   logic [DCNT_BITS-1:0] max_decay;

   assign csr_pready = 1'b1;

   bmph_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .decay_mask (decay_mask),
      .max_decay  (max_decay)
   );

   bmph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmph_dp #(
      .ROWS     (ROWS),
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_channel (req_bus.channel),
      .req_level   (req_bus.level),
      .decay_mask  (decay_mask),
      .max_decay   (max_decay),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_x_start (rsp_bus.x_start),
      .rsp_row     (rsp_bus.row),
      .rsp_color   (rsp_bus.color),
      .rsp_is_peak (rsp_bus.is_peak),
      .rsp_last    (rsp_bus.last)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && stat.chan_ok |=> !req_bus.ready)
      else $error("level transaction accepted but sequencer still idle");

   a_last_is_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last == rsp_bus.is_peak))
      else $error("last flag and peak flag disagree");

   a_peak_color: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_peak |-> (rsp_bus.color == PEAK_COLOR))
      else $error("peak segment with wrong color");
`endif

endmodule
